// ===== design/matrix_multiply_assert.svh =====
// Assertion macros used by the matrix multiplier back end (mm_back).
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

`define MM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matrix multiply assertion failed");

`define MM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matrix multiply assertion failed");

`endif

// ===== design/mm_pkg.sv =====
package mm_pkg;

    localparam int DIM_W = 4;
    localparam int LIN_W = 2 * DIM_W;
    localparam int OUT_W = 35;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B = 2'd2;

    typedef struct packed {
        logic             is_b;
        logic             done;
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nk;
        logic [DIM_W-1:0] nc;
    } mm_cmd_t;

endpackage

// ===== design/mm_front.sv =====
module mm_front
    import mm_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int DATA_WIDTH = 16,
    parameter int ADDR_W = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [DIM_W-1:0]      rows_a,
    input  logic [DIM_W-1:0]      inner_dim,
    input  logic [DIM_W-1:0]      cols_b,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] in_data,
    input  logic                  queue_full,
    output logic                  push,
    output mm_cmd_t               push_cmd,
    output logic [ADDR_W-1:0]     push_addr,
    output logic [DATA_WIDTH-1:0] push_data
);

    localparam int CNT_W = $clog2(2 * MAX_DIM * MAX_DIM + 1);
    localparam logic [DIM_W-1:0] DIM_CAP = (MAX_DIM > 15) ? DIM_W'(15) : DIM_W'(MAX_DIM);

    logic [CNT_W-1:0] load_count_reg;
    logic [CNT_W-1:0] load_count_next;
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;
    logic [CNT_W-1:0] na;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] offset;
    logic             is_b;
    logic             done;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] d;
        begin
            if (r == '0)
            begin
                d = DIM_W'(1);
            end
            else if (r > DIM_CAP)
            begin
                d = DIM_CAP;
            end
            else
            begin
                d = r;
            end
            return d;
        end
    endfunction

    always_comb
    begin
        nr = eff_dim(rows_a);
        nk = eff_dim(inner_dim);
        nc = eff_dim(cols_b);
        na = CNT_W'(nr) * CNT_W'(nk);
        total = na + CNT_W'(nk) * CNT_W'(nc);
        cnt = (load_count_reg >= total) ? '0 : load_count_reg;
        is_b = (cnt >= na);
        offset = is_b ? (cnt - na) : cnt;
        cnt_inc = cnt + CNT_W'(1);
        done = (cnt_inc == total);
    end

    assign in_ready = !queue_full;
    assign push = in_valid && in_ready;
    assign push_addr = offset[ADDR_W-1:0];
    assign push_data = in_data;

    always_comb
    begin
        push_cmd.is_b = is_b;
        push_cmd.done = done;
        push_cmd.nr = nr;
        push_cmd.nk = nk;
        push_cmd.nc = nc;
    end

    always_comb
    begin
        load_count_next = load_count_reg;
        if (push)
        begin
            load_count_next = done ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
        end
        else
        begin
            load_count_reg <= load_count_next;
        end
    end

endmodule

// ===== design/mm_queue.sv =====
module mm_queue
    import mm_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/mm_back.sv =====
`include "matrix_multiply_assert.svh"

module mm_back
    import mm_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int DATA_WIDTH = 16,
    parameter int ADDR_W = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  empty,
    output logic                  pop,
    input  mm_cmd_t               pop_cmd,
    input  logic [ADDR_W-1:0]     pop_addr,
    input  logic [DATA_WIDTH-1:0] pop_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_W-1:0]      out_data,
    output logic                  out_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } mm_state_t;

    mm_state_t state_reg;
    mm_state_t state_next;

    logic [DATA_WIDTH-1:0] a_mem [DEPTH];
    logic [DATA_WIDTH-1:0] b_mem [DEPTH];

    logic [DIM_W-1:0] i_reg;
    logic [DIM_W-1:0] i_next;
    logic [DIM_W-1:0] j_reg;
    logic [DIM_W-1:0] j_next;
    logic [DIM_W-1:0] k_reg;
    logic [DIM_W-1:0] k_next;
    logic [DIM_W-1:0] nr_reg;
    logic [DIM_W-1:0] nr_next;
    logic [DIM_W-1:0] nk_reg;
    logic [DIM_W-1:0] nk_next;
    logic [DIM_W-1:0] nc_reg;
    logic [DIM_W-1:0] nc_next;

    logic wr_a;
    logic wr_b;
    logic en;
    logic issue;
    logic last_k;
    logic last_j;
    logic last_i;
    logic [LIN_W-1:0]  a_lin;
    logic [LIN_W-1:0]  b_lin;
    logic [ADDR_W-1:0] a_raddr;
    logic [ADDR_W-1:0] b_raddr;

    logic                         s1_valid_reg;
    logic                         s1_first_reg;
    logic                         s1_lastk_reg;
    logic                         s1_lastel_reg;
    logic signed [DATA_WIDTH-1:0] a_rd_reg;
    logic signed [DATA_WIDTH-1:0] b_rd_reg;

    logic                           s2_valid_reg;
    logic                           s2_first_reg;
    logic                           s2_lastk_reg;
    logic                           s2_lastel_reg;
    logic signed [2*DATA_WIDTH-1:0] prod_reg;

    logic signed [OUT_W-1:0] prod_ext;
    logic signed [OUT_W-1:0] acc_reg;
    logic signed [OUT_W-1:0] acc_next;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;
    logic                    out_last_reg;

    assign en = !out_valid_reg || out_ready;
    assign issue = (state_reg == ST_SWEEP);
    assign last_k = (k_reg == nk_reg - DIM_W'(1));
    assign last_j = (j_reg == nc_reg - DIM_W'(1));
    assign last_i = (i_reg == nr_reg - DIM_W'(1));
    assign a_lin = LIN_W'(i_reg) * LIN_W'(nk_reg) + LIN_W'(k_reg);
    assign b_lin = LIN_W'(k_reg) * LIN_W'(nc_reg) + LIN_W'(j_reg);
    assign a_raddr = a_lin[ADDR_W-1:0];
    assign b_raddr = b_lin[ADDR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        nr_next = nr_reg;
        nk_next = nk_reg;
        nc_next = nc_reg;
        pop = 1'b0;
        wr_a = 1'b0;
        wr_b = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    wr_a = !pop_cmd.is_b;
                    wr_b = pop_cmd.is_b;
                    if (pop_cmd.done)
                    begin
                        state_next = ST_SWEEP;
                        nr_next = pop_cmd.nr;
                        nk_next = pop_cmd.nk;
                        nc_next = pop_cmd.nc;
                        i_next = '0;
                        j_next = '0;
                        k_next = '0;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (en)
                begin
                    if (!last_k)
                    begin
                        k_next = k_reg + DIM_W'(1);
                    end
                    else
                    begin
                        k_next = '0;
                        if (!last_j)
                        begin
                            j_next = j_reg + DIM_W'(1);
                        end
                        else
                        begin
                            j_next = '0;
                            if (!last_i)
                            begin
                                i_next = i_reg + DIM_W'(1);
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            nr_reg <= DIM_W'(1);
            nk_reg <= DIM_W'(1);
            nc_reg <= DIM_W'(1);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            nr_reg <= nr_next;
            nk_reg <= nk_next;
            nc_reg <= nc_next;
            if (en)
            begin
                s1_valid_reg <= issue;
                s2_valid_reg <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg && s2_lastk_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            a_mem[pop_addr] <= pop_data;
        end
        if (wr_b)
        begin
            b_mem[pop_addr] <= pop_data;
        end
        if (en)
        begin
            a_rd_reg <= a_mem[a_raddr];
            b_rd_reg <= b_mem[b_raddr];
        end
    end

    assign prod_ext = OUT_W'(prod_reg);
    assign acc_next = s2_first_reg ? prod_ext : acc_reg + prod_ext;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_first_reg <= (k_reg == '0);
            s1_lastk_reg <= last_k;
            s1_lastel_reg <= last_k && last_j && last_i;
            s2_first_reg <= s1_first_reg;
            s2_lastk_reg <= s1_lastk_reg;
            s2_lastel_reg <= s1_lastel_reg;
            prod_reg <= a_rd_reg * b_rd_reg;
            if (s2_valid_reg)
            begin
                acc_reg <= acc_next;
            end
            if (s2_valid_reg && s2_lastk_reg)
            begin
                out_data_reg <= acc_next;
                out_last_reg <= s2_lastel_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

    `MM_ASSERT_IMPL(a_sweep_in_range, state_reg == ST_SWEEP, (k_reg < nk_reg) && (j_reg < nc_reg) && (i_reg < nr_reg))
    `MM_ASSERT_NEXT(a_stall_freezes, (state_reg == ST_SWEEP) && !en, (k_reg == $past(k_reg)) && (s1_valid_reg == $past(s1_valid_reg)))
    `MM_ASSERT_NEXT(a_result_on_last_k, en && s2_valid_reg && s2_lastk_reg, out_valid_reg)

endmodule

// ===== design/matrix_multiply.sv =====
// Dense matrix multiplier, C = A x B, on signed Q8.8 elements with full-precision Q19.16
// results. Elements arrive on the slave stream in row-major order, first the rows_a x
// inner_dim elements of A and then the inner_dim x cols_b elements of B; a register that
// holds zero acts as one and a value above MAX_DIM acts as MAX_DIM. Elements are taken in
// while the two-entry command queue has room, so loading runs at one transfer per cycle.
// The transfer that completes B starts a sweep of the single multiply-accumulate unit,
// which reads one element of each store per cycle while the output is not stalled; each
// product passes through the read registers and the product register into the
// accumulator. During the sweep at most two further elements are taken in before the
// input stalls. Results leave in row-major order with tlast on the final element; a stalled
// output holds the whole sweep. The dimension registers are to be written only while the
// block is idle.
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM = 8,
    parameter int DATA_WIDTH = 16
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // element_value in the low DATA_WIDTH bits, zero padding above
    input  logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0]  s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // product_value in bits 34:0, zero padding above
    output logic [OUT_TDATA_W-1:0]                   m_tdata,
    output logic                                     m_tlast,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [CFG_ADDR_W-1:0]                    paddr,
    input  logic [CFG_DATA_W-1:0]                    pwdata,
    output logic [CFG_DATA_W-1:0]                    prdata,
    output logic                                     pready
);

    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int CMD_W = $bits(mm_cmd_t);
    localparam int QW = DATA_WIDTH + ADDR_W + CMD_W;

    logic [DIM_W-1:0] rows_a_reg;
    logic [DIM_W-1:0] inner_dim_reg;
    logic [DIM_W-1:0] cols_b_reg;
    logic             cfg_write;
    logic [1:0]       cfg_index;

    logic                  queue_full;
    logic                  queue_empty;
    logic                  push;
    logic                  pop;
    mm_cmd_t               push_cmd;
    mm_cmd_t               pop_cmd;
    logic [ADDR_W-1:0]     push_addr;
    logic [ADDR_W-1:0]     pop_addr;
    logic [DATA_WIDTH-1:0] push_data;
    logic [DATA_WIDTH-1:0] pop_data;
    logic [QW-1:0]         queue_in;
    logic [QW-1:0]         queue_out;
    logic [OUT_W-1:0]      result;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= DIM_W'(1);
            inner_dim_reg <= DIM_W'(1);
            cols_b_reg <= DIM_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg <= pwdata[DIM_W-1:0];
                REG_INNER_DIM: inner_dim_reg <= pwdata[DIM_W-1:0];
                REG_COLS_B:    cols_b_reg <= pwdata[DIM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_ROWS_A:    prdata = CFG_DATA_W'(rows_a_reg);
            REG_INNER_DIM: prdata = CFG_DATA_W'(inner_dim_reg);
            REG_COLS_B:    prdata = CFG_DATA_W'(cols_b_reg);
            default:       prdata = '0;
        endcase
    end

    mm_front #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rows_a     (rows_a_reg),
        .inner_dim  (inner_dim_reg),
        .cols_b     (cols_b_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata[DATA_WIDTH-1:0]),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_addr  (push_addr),
        .push_data  (push_data)
    );

    assign queue_in = {push_data, push_addr, push_cmd};
    assign pop_cmd = queue_out[CMD_W-1:0];
    assign pop_addr = queue_out[CMD_W +: ADDR_W];
    assign pop_data = queue_out[CMD_W + ADDR_W +: DATA_WIDTH];

    mm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (queue_in),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (queue_out),
        .empty     (queue_empty)
    );

    mm_back #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .pop_addr  (pop_addr),
        .pop_data  (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result),
        .out_last  (m_tlast)
    );

    assign m_tdata = {(OUT_TDATA_W - OUT_W)'(0), result};

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    import mm_pkg::*;

    localparam int MAX_DIM = 8;
    localparam int DATA_WIDTH = 16;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int IDLE_PERCENT = 13;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 215;

    typedef struct {
        logic [OUT_W-1:0] product_value;
        logic             last_element;
    } product_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    // element_value
    logic [DATA_WIDTH-1:0]        s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    // product_value, zero padding
    logic [OUT_TDATA_W-1:0]       m_tdata;
    logic                         m_tlast;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [CFG_ADDR_W-1:0]        paddr;
    logic [CFG_DATA_W-1:0]        pwdata;
    logic [CFG_DATA_W-1:0]        prdata;
    logic                         pready;

    logic [DIM_W-1:0]             rows_a_reg = 1;
    logic [DIM_W-1:0]             inner_dim_reg = 1;
    logic [DIM_W-1:0]             cols_b_reg = 1;
    logic signed [DATA_WIDTH-1:0] a_elems [STORE_DEPTH];
    logic signed [DATA_WIDTH-1:0] b_elems [STORE_DEPTH];
    int unsigned                  elements_loaded = 0;
    product_t                     product_q [$];

    int                           mismatch_count = 0;
    int                           idle_cycles = 0;
    int                           hold_request = 0;
    int                           hold_left = 0;
    bit                           source_gaps = 1'b1;
    bit                           sink_gaps = 1'b1;

    matrix_multiply #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    function automatic int unsigned effective_dim(input logic [DIM_W-1:0] value);
        if (value == 0)
        begin
            return 1;
        end
        if (value > MAX_DIM)
        begin
            return MAX_DIM;
        end
        return value;
    endfunction

    function automatic int unsigned matrix_elements();
        int unsigned nk;
        nk = effective_dim(inner_dim_reg);
        return nk * (effective_dim(rows_a_reg) + effective_dim(cols_b_reg));
    endfunction

    // Stores one element and, when it completes B, queues every element of C.
    function automatic void load_element(input logic [DATA_WIDTH-1:0] raw);
        int unsigned nr;
        int unsigned nk;
        int unsigned nc;
        int unsigned na;
        int unsigned total;
        logic signed [OUT_W-1:0] acc;
        product_t item;
        nr = effective_dim(rows_a_reg);
        nk = effective_dim(inner_dim_reg);
        nc = effective_dim(cols_b_reg);
        na = nr * nk;
        total = na + nk * nc;
        if (elements_loaded >= total)
        begin
            elements_loaded = 0;
        end
        if (elements_loaded < na)
        begin
            a_elems[elements_loaded % STORE_DEPTH] = raw;
        end
        else
        begin
            b_elems[(elements_loaded - na) % STORE_DEPTH] = raw;
        end
        elements_loaded++;
        if (elements_loaded < total)
        begin
            return;
        end
        elements_loaded = 0;
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                acc = '0;
                for (int k = 0; k < nk; k++)
                begin
                    acc = acc + a_elems[(i * nk + k) % STORE_DEPTH] *
                                b_elems[(k * nc + j) % STORE_DEPTH];
                end
                item.product_value = acc;
                item.last_element = (i == nr - 1) && (j == nc - 1);
                product_q.push_back(item);
            end
        end
    endfunction

    function automatic logic [DATA_WIDTH-1:0] random_element();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return DATA_WIDTH'($urandom_range(1024));
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        if ($urandom_range(5) == 0)
        begin
            return DIM_W'($urandom_range(15));
        end
        return DIM_W'($urandom_range(1, 3));
    endfunction

    task automatic send_element(input logic [DATA_WIDTH-1:0] value);
        while (source_gaps && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= value;
        do
            @(posedge clk);
        while (!s_tready);
        load_element(value);
    endtask

    task automatic send_matrices(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_element(random_element());
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (product_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [DIM_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'({index, 2'b00});
        pwdata <= ($urandom() & ~CFG_DATA_W'(4'hF)) | CFG_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_ROWS_A: rows_a_reg = value;
            REG_INNER_DIM: inner_dim_reg = value;
            REG_COLS_B: cols_b_reg = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] inner,
                            input logic [DIM_W-1:0] cols);
        write_reg(REG_ROWS_A, rows);
        write_reg(REG_INNER_DIM, inner);
        write_reg(REG_COLS_B, cols);
    endtask

    task automatic test_unit_extremes();
        send_element(16'h7FFF);
        send_element(16'h7FFF);
        send_element(16'h8000);
        send_element(16'h8000);
        send_element(16'h8000);
        send_element(16'h7FFF);
        send_element(16'h0000);
        send_element(16'hFFFF);
        wait_drained();
    endtask

    // A zero register acts as one and a value above the maximum as the maximum.
    task automatic test_register_clamping();
        set_dims(4'd15, 4'd0, 4'd1);
        send_matrices(matrix_elements());
        wait_drained();
    endtask

    // New dimensions below the loaded count restart loading at the first element of A.
    task automatic test_midload_restart();
        set_dims(4'd2, 4'd2, 4'd2);
        send_matrices(5);
        wait_drained();
        set_dims(4'd1, 4'd1, 4'd1);
        send_matrices(2);
        wait_drained();
    endtask

    task automatic test_full_size();
        source_gaps = 1'b0;
        sink_gaps = 1'b0;
        set_dims(DIM_W'($urandom_range(8, 15)), DIM_W'($urandom_range(8, 15)),
                 DIM_W'($urandom_range(8, 15)));
        send_matrices(matrix_elements());
        wait_drained();
        source_gaps = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_output_stall();
        set_dims(4'd2, 4'd2, 4'd2);
        hold_request = HOLD_OFF_CYCLES;
        send_matrices(3 * matrix_elements());
        wait_drained();
    endtask

    task automatic test_pause_between_matrices();
        set_dims(4'd3, 4'd1, 4'd2);
        for (int n = 0; n < 3; n++)
        begin
            send_matrices(matrix_elements());
            wait_drained();
        end
    endtask

    // Every store entry has been written by now, so dimensions may change mid-load.
    task automatic test_random_products();
        int sent;
        int total;
        int partial;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_dims(random_dim(), random_dim(), random_dim());
            total = matrix_elements();
            for (int m = $urandom_range(1, 3); m > 0; m--)
            begin
                if ($urandom_range(4) == 0)
                begin
                    partial = $urandom_range(1, total - 1);
                    send_matrices(partial);
                    sent += partial;
                    break;
                end
                send_matrices(total);
                sent += total;
            end
            wait_drained();
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= !(sink_gaps && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk)
    begin
        product_t expected;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (product_q.size() == 0)
            begin
                $error("product_value: unexpected transfer, actual %0d",
                       $signed(m_tdata[OUT_W-1:0]));
                mismatch_count++;
            end
            else
            begin
                expected = product_q.pop_front();
                if (m_tdata[OUT_W-1:0] !== expected.product_value)
                begin
                    $error("product_value: expected %0d, actual %0d",
                           $signed(expected.product_value), $signed(m_tdata[OUT_W-1:0]));
                    mismatch_count++;
                end
                if (m_tlast !== expected.last_element)
                begin
                    $error("last_element: expected %0b, actual %0b",
                           expected.last_element, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        for (int n = 0; n < STORE_DEPTH; n++)
        begin
            a_elems[n] = '0;
            b_elems[n] = '0;
        end
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unit_extremes();
        test_register_clamping();
        test_midload_restart();
        test_full_size();
        test_output_stall();
        test_pause_between_matrices();
        test_random_products();
        wait_drained();
        if (mismatch_count == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/mm_pkg.sv
design/mm_front.sv
design/mm_queue.sv
design/mm_back.sv
design/matrix_multiply.sv
tb/sv/testbench.sv
